[rtl/srch_pkg.sv]
// ----------------------------------------------------------------------------
// srch_pkg: shared types and constants for the equal-range search block
// Sizes of the value store, index encodings, the transaction record that
// travels from the front end to the search engine, and queue status.
// ----------------------------------------------------------------------------
package srch_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   // Search bounds span -1 .. MAX_ENTRIES and the sum of two bounds
   localparam int POS_W       = ADDR_W + 2;
   localparam int VALUE_W     = 32;
   localparam int LEN_W       = 11;
   localparam int ELEM_IDX_W  = 10;
   localparam int RSP_IDX_W   = 11;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef logic signed [POS_W-1:0] pos_type;

   localparam logic signed [RSP_IDX_W-1:0] NOT_FOUND_INDEX = '1;

   typedef struct packed {
      logic                      is_query;
      logic [ADDR_W-1:0]         addr;
      logic signed [VALUE_W-1:0] value;
   } xact_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[rtl/srch_ram.sv]
// ----------------------------------------------------------------------------
// srch_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/srch_front.sv]
// ----------------------------------------------------------------------------
// srch_front: request front end
// Accept transactions, classify them as load or query, drop loads whose
// index lies outside the store, and push the rest into the queue.
// ----------------------------------------------------------------------------
module srch_front (
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_opcode,
   input  logic [srch_pkg::ELEM_IDX_W-1:0]        req_element_index,
   input  logic signed [srch_pkg::VALUE_W-1:0]    req_data_value,
   input  srch_pkg::queue_status_type             queue_status,
   output logic                                   push,
   output srch_pkg::xact_type                     push_data
);
   import srch_pkg::*;

   logic accept;
   logic in_range;
   logic is_query;

   assign busy     = queue_status.full;
   assign accept   = start && !queue_status.full;
   assign is_query = (req_opcode == OP_QUERY);
   assign in_range = (int'(req_element_index) < MAX_ENTRIES);
   assign push     = accept && (is_query || in_range);

   assign push_data.is_query = is_query;
   assign push_data.addr     = ADDR_W'(req_element_index);
   assign push_data.value    = req_data_value;

endmodule

[rtl/srch_queue.sv]
// ----------------------------------------------------------------------------
// srch_queue: transaction queue between front end and search engine
// Small register FIFO; lets the front keep accepting while a search runs.
// ----------------------------------------------------------------------------
module srch_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  srch_pkg::xact_type          push_data,
   input  logic                        pop,
   output srch_pkg::xact_type          pop_data,
   output srch_pkg::queue_status_type  status
);
   import srch_pkg::*;

   xact_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_data     = slots_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/srch_back.sv]
// ----------------------------------------------------------------------------
// srch_back: search engine
// Pop transactions; write loads into the value store, run queries as a
// middle search followed, on a hit, by left-end and right-end searches, one
// probe of the store per cycle, and register the result strobe.
// ----------------------------------------------------------------------------
module srch_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [srch_pkg::LEN_W-1:0]           array_length,
   input  srch_pkg::queue_status_type           queue_status,
   input  srch_pkg::xact_type                   queue_data,
   output logic                                 pop,
   output logic                                 ram_wr_en,
   output logic [srch_pkg::ADDR_W-1:0]          ram_wr_addr,
   output logic [srch_pkg::VALUE_W-1:0]         ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [srch_pkg::ADDR_W-1:0]          ram_rd_addr,
   input  logic [srch_pkg::VALUE_W-1:0]         ram_rd_data,
   output logic                                 rsp_valid,
   output logic signed [srch_pkg::RSP_IDX_W-1:0] rsp_first_index,
   output logic signed [srch_pkg::RSP_IDX_W-1:0] rsp_last_index,
   output logic                                 rsp_found
);
   import srch_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAIN,
      ST_LEFT,
      ST_RIGHT
   } state_type;

   state_type                    state_ff, state_in;
   pos_type                      lo_ff, lo_in, hi_ff, hi_in;
   pos_type                      l_ff, l_in, r_ff, r_in;
   pos_type                      mid_ff, mid_in, probe_ff, probe_in;
   pos_type                      first_ff, first_in;
   pos_type                      len_pos;
   logic signed [VALUE_W-1:0]    target_ff, target_in;
   logic signed [VALUE_W-1:0]    probe_value;
   logic                         rsp_valid_in, rsp_found_in;
   logic signed [RSP_IDX_W-1:0]  rsp_first_in, rsp_last_in;
   logic                         go_main, go_left, go_right;
   logic                         hit;

   assign len_pos     = (int'(array_length) > MAX_ENTRIES) ? pos_type'(MAX_ENTRIES)
                                                           : pos_type'(array_length);
   assign probe_value = $signed(ram_rd_data);
   assign hit         = (probe_value == target_ff);
   assign ram_rd_addr = probe_in[ADDR_W-1:0];
   assign ram_wr_addr = queue_data.addr;
   assign ram_wr_data = queue_data.value;

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      mid_in       = mid_ff;
      probe_in     = probe_ff;
      first_in     = first_ff;
      target_in    = target_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found;
      rsp_first_in = rsp_first_index;
      rsp_last_in  = rsp_last_index;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      go_main      = 1'b0;
      go_left      = 1'b0;
      go_right     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               pop = 1'b1;
               if (queue_data.is_query) begin
                  target_in = queue_data.value;
                  lo_in     = '0;
                  hi_in     = len_pos - pos_type'(1);
                  go_main   = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
               end
            end
         end
         ST_MAIN: begin
            if (hit) begin
               mid_in  = probe_ff;
               l_in    = lo_ff;
               r_in    = probe_ff;
               go_left = 1'b1;
            end else begin
               if (probe_value < target_ff) begin
                  lo_in = probe_ff + pos_type'(1);
               end else begin
                  hi_in = probe_ff - pos_type'(1);
               end
               go_main = 1'b1;
            end
         end
         ST_LEFT: begin
            if (hit) begin
               r_in = probe_ff;
            end else begin
               l_in = probe_ff + pos_type'(1);
            end
            go_left = 1'b1;
         end
         ST_RIGHT: begin
            if (hit) begin
               l_in = probe_ff;
            end else begin
               r_in = probe_ff - pos_type'(1);
            end
            go_right = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Issue the next probe of the middle search, or report a miss
      if (go_main) begin
         if (lo_in <= hi_in) begin
            probe_in  = (lo_in + hi_in) >>> 1;
            ram_rd_en = 1'b1;
            state_in  = ST_MAIN;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b0;
            rsp_first_in = NOT_FOUND_INDEX;
            rsp_last_in  = NOT_FOUND_INDEX;
            state_in     = ST_IDLE;
         end
      end

      // Left end: r always holds a match, so l is the answer once they meet
      if (go_left) begin
         if (l_in < r_in) begin
            probe_in  = (l_in + r_in) >>> 1;
            ram_rd_en = 1'b1;
            state_in  = ST_LEFT;
         end else begin
            first_in = l_in;
            l_in     = mid_in;
            r_in     = hi_in;
            go_right = 1'b1;
         end
      end

      // Right end: l always holds a match
      if (go_right) begin
         if (l_in < r_in) begin
            probe_in  = ((l_in + r_in) >>> 1) + pos_type'(1);
            ram_rd_en = 1'b1;
            state_in  = ST_RIGHT;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            rsp_first_in = RSP_IDX_W'(first_in);
            rsp_last_in  = RSP_IDX_W'(l_in);
            state_in     = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= rsp_valid_in;
      end
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      l_ff            <= l_in;
      r_ff            <= r_in;
      mid_ff          <= mid_in;
      probe_ff        <= probe_in;
      first_ff        <= first_in;
      target_ff       <= target_in;
      rsp_found       <= rsp_found_in;
      rsp_first_index <= rsp_first_in;
      rsp_last_index  <= rsp_last_in;
   end

endmodule

[rtl/sorted_array_equal_range_search.sv]
// ----------------------------------------------------------------------------
// sorted_array_equal_range_search: equal-range search over a sorted store
// Holds up to MAX_ENTRIES signed 32-bit values and answers, for a target,
// the lowest and highest index that holds it.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A load writes
// one value into the store and gives no result; a query gives exactly one
// result, shown for one cycle with rsp_valid high. The receiver cannot hold
// results off, so take them as they come. Loads and queries pass through a
// two-entry queue, so busy rises only while that queue is full. The search
// engine takes a new transaction only once it is done with the last one. A
// query probes the store one probe after another, since each probe's
// registered read decides the next address. The middle search takes at most
// log2(n)+1 probes, n being the array length register; the left-end and
// right-end searches then split only the range the middle search left open,
// so the longest query is a hit on the very first probe. The result strobe
// is registered from the decision on the last probe's read data. The store
// has no reset and no clearing pass: its entries hold nothing until loaded,
// and a query must cover only loaded entries. Keep the loaded values in
// ascending order. Write the array length register only while the block is
// idle; values above MAX_ENTRIES act as MAX_ENTRIES, and loads to an index
// beyond the store are dropped.
// ----------------------------------------------------------------------------
module sorted_array_equal_range_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [srch_pkg::ELEM_IDX_W-1:0]       req_element_index,
   input  logic signed [srch_pkg::VALUE_W-1:0]   req_data_value,
   input  logic                                  csr_write_enable,
   input  logic [srch_pkg::LEN_W-1:0]            csr_write_data,
   output logic                                  rsp_valid,
   output logic signed [srch_pkg::RSP_IDX_W-1:0] rsp_first_index,
   output logic signed [srch_pkg::RSP_IDX_W-1:0] rsp_last_index,
   output logic                                  rsp_found
);
   import srch_pkg::*;

   // Array length register
   logic [LEN_W-1:0]      array_length_ff;

   // Front end to queue
   logic                  q_push;
   xact_type              q_push_data;

   // Queue to search engine
   logic                  q_pop;
   xact_type              q_pop_data;
   queue_status_type      q_status;

   // Value store ports
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [VALUE_W-1:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [VALUE_W-1:0]    ram_rd_data;

   // Hold the length until software writes it again
   always_ff @(posedge clock) begin
      if (reset) begin
         array_length_ff <= '0;
      end else if (csr_write_enable) begin
         array_length_ff <= csr_write_data;
      end
   end

   // Accept and classify each transaction
   srch_front u_front (
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_element_index (req_element_index),
      .req_data_value    (req_data_value),
      .queue_status      (q_status),
      .push              (q_push),
      .push_data         (q_push_data)
   );

   // Decouple the front end from the search engine
   srch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Execute loads and searches, one store access per cycle
   srch_back u_back (
      .clock           (clock),
      .reset           (reset),
      .array_length    (array_length_ff),
      .queue_status    (q_status),
      .queue_data      (q_pop_data),
      .pop             (q_pop),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index),
      .rsp_found       (rsp_found)
   );

   // Value store
   srch_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A miss reports no index at either end
   a_miss_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         rsp_first_index == NOT_FOUND_INDEX && rsp_last_index == NOT_FOUND_INDEX)
      else $error("miss result carries an index");

   // A hit spans a non-empty, ordered range inside the store
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         rsp_first_index >= 0 && rsp_first_index <= rsp_last_index)
      else $error("hit result range is malformed");

   // The front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("transaction pushed into full queue");

   // The store is never written and probed in the same cycle
   a_store_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store written during a search probe");

endmodule
